// File: hdl/aasit_pkg.sv
`default_nettype none

package aasit_pkg;

    // table geometry
    localparam int NUM_ENTRIES = 256;
    localparam int IDX_W       = $clog2(NUM_ENTRIES);
    localparam int MAX_ASSOC   = 16;
    localparam int MAX_LG      = $clog2(MAX_ASSOC);
    localparam int LG_W        = $clog2(MAX_LG + 1);
    localparam int INIT_ASSOC  = 4;
    localparam int INIT_LG     = $clog2(INIT_ASSOC);

    // slot word: valid bit over the entry id
    localparam int ENTRY_W     = 8;
    localparam int SLOT_W      = ENTRY_W + 1;
    localparam int SLOT_AW     = IDX_W + 1;
    localparam int FILL_W      = $clog2(MAX_ASSOC + 1);

    // item fields
    localparam int ADDR_W      = 64;
    localparam int NA_W        = 9;
    localparam int BOB_W       = 4;
    localparam int BOB_RESET   = 6;
    localparam int SHIFT_W     = $clog2((2 ** BOB_W) + IDX_W);

    typedef enum logic [1:0] {
        FUNC_LOOKUP = 2'd0,
        FUNC_PLACE  = 2'd1,
        FUNC_ASSOC  = 2'd2,
        FUNC_REGEN  = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_BAD_ASSOC  = 2'd1,
        STATUS_SLOT_RANGE = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_INIT_CLR,
        S_IDLE,
        S_LOOKUP,
        S_REB_CLR,
        S_REB_RD,
        S_REB_FILL,
        S_REB_WR,
        S_REB_END
    } t_state;

endpackage

`default_nettype wire

// File: hdl/aasit_ram.sv
`default_nettype none

module aasit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/adaptive_assoc_set_index_table.sv
`default_nettype none

// set/way placement table for a cache whose associativity changes at run time.
// an item is taken when start is high and busy is low; results leave on the
// o_ ports, each valid for the single cycle in which o_strobe is high, and the
// receiver cannot hold them off. o_last marks the final result of an item.
// what each function does, paced by the single write and single read port of the slot memory:
//   lookup: 2^assoc_log2 results, one per cycle, each through the registered
//     slot memory read and the output registers; busy until the last read returns
//   place, regenerate, and an associativity change that is rejected or
//     unchanged: one result the cycle after start; busy stays low
//   associativity rebuild: a clear of the spare bank and the fill counters,
//     then a walk that reads each slot of the current bank and writes each valid
//     one into the first free way of its new set, then one status result; busy
//     stays high from start until that result appears
// after reset, busy stays high while bank 0 is cleared; the block offset
// register may be written during that time.
// the slot table is one 512 x 9 memory (two banks of 256 slots, valid bit over
// entry id); the per-set fill counters of a rebuild are a 256 x 5 memory.

module adaptive_assoc_set_index_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    // configuration: block offset bits
    input  wire logic        i_cfg_we,
    input  wire logic [3:0]  i_cfg_wdata,

    // item in
    input  wire logic        start,
    output      logic        busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [63:0] i_address,
    input  wire logic [63:0] i_tag_in,
    input  wire logic [7:0]  i_set_in,
    input  wire logic [7:0]  i_slot_index,
    input  wire logic [7:0]  i_entry_id,
    input  wire logic [8:0]  i_ways_req,

    // results out
    output      logic        o_strobe,
    output      logic [7:0]  o_set_index,
    output      logic [63:0] o_tag_out,
    output      logic [7:0]  o_way,
    output      logic [7:0]  o_entry_out,
    output      logic        o_entry_valid,
    output      logic [63:0] o_address_out,
    output      logic [1:0]  o_status,
    output      logic        o_last
);

    // control state
    aasit_pkg::t_state r_state, n_state;
    logic                           r_bank, n_bank;
    logic [aasit_pkg::LG_W-1:0]     r_lg, n_lg;
    logic [aasit_pkg::LG_W-1:0]     r_new_lg, n_new_lg;
    logic [aasit_pkg::FILL_W-1:0]   r_na, n_na;
    logic [aasit_pkg::BOB_W-1:0]    r_bob;
    logic [aasit_pkg::IDX_W-1:0]    r_cnt, n_cnt;
    logic                           r_lk_pend, n_lk_pend;

    // item working registers
    logic [aasit_pkg::IDX_W-1:0]    r_set, n_set;
    logic [aasit_pkg::ADDR_W-1:0]   r_tag, n_tag;
    logic [aasit_pkg::IDX_W-1:0]    r_lk_way, n_lk_way;
    logic                           r_lk_last, n_lk_last;
    logic [aasit_pkg::SLOT_W-1:0]   r_ent, n_ent;
    logic [aasit_pkg::IDX_W-1:0]    r_tgt, n_tgt;

    // output registers
    logic                           r_o_strobe, n_o_strobe;
    logic [7:0]                     r_o_set, n_o_set;
    logic [63:0]                    r_o_tag, n_o_tag;
    logic [7:0]                     r_o_way, n_o_way;
    logic [7:0]                     r_o_ent, n_o_ent;
    logic                           r_o_val, n_o_val;
    logic [63:0]                    r_o_addr, n_o_addr;
    logic [1:0]                     r_o_status, n_o_status;
    logic                           r_o_last, n_o_last;

    // memory ports
    logic                           slot_we;
    logic [aasit_pkg::SLOT_AW-1:0]  slot_waddr;
    logic [aasit_pkg::SLOT_W-1:0]   slot_wdata;
    logic [aasit_pkg::SLOT_AW-1:0]  slot_raddr;
    logic [aasit_pkg::SLOT_W-1:0]   slot_rdata;
    logic                           fill_we;
    logic [aasit_pkg::IDX_W-1:0]    fill_waddr;
    logic [aasit_pkg::FILL_W-1:0]   fill_wdata;
    logic [aasit_pkg::IDX_W-1:0]    fill_raddr;
    logic [aasit_pkg::FILL_W-1:0]   fill_rdata;

    // decode
    logic                           accept;
    logic                           cnt_max;
    logic [aasit_pkg::IDX_W-1:0]    assoc_m1;
    logic [aasit_pkg::IDX_W-1:0]    smask;
    logic [aasit_pkg::IDX_W:0]      sets;
    logic [aasit_pkg::SHIFT_W-1:0]  tshift;
    logic [aasit_pkg::IDX_W-1:0]    lk_set;
    logic [aasit_pkg::ADDR_W-1:0]   lk_tag;
    logic [aasit_pkg::IDX_W-1:0]    pl_set;
    logic [aasit_pkg::IDX_W-1:0]    pl_way;
    logic                           na_pow2;
    logic                           na_ok;
    logic                           na_same;
    logic                           assoc_go;
    logic [aasit_pkg::LG_W-1:0]     nl_dec;
    logic [aasit_pkg::IDX_W-1:0]    ns_mask;
    logic [aasit_pkg::IDX_W-1:0]    walk_tgt;

    aasit_ram #(
        .WIDTH (aasit_pkg::SLOT_W),
        .DEPTH (2 * aasit_pkg::NUM_ENTRIES)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    aasit_ram #(
        .WIDTH (aasit_pkg::FILL_W),
        .DEPTH (aasit_pkg::NUM_ENTRIES)
    ) u_fill_ram (
        .i_clk   (i_clk),
        .i_we    (fill_we),
        .i_waddr (fill_waddr),
        .i_wdata (fill_wdata),
        .i_raddr (fill_raddr),
        .o_rdata (fill_rdata)
    );

    // busy covers the cycle in which the last lookup read returns
    assign busy   = (r_state != aasit_pkg::S_IDLE) || r_lk_pend;
    assign accept = start && !busy;
    assign cnt_max = (r_cnt == {aasit_pkg::IDX_W{1'b1}});

    // current geometry
    assign assoc_m1 = (aasit_pkg::IDX_W'(1) << r_lg) - aasit_pkg::IDX_W'(1);
    assign smask    = {aasit_pkg::IDX_W{1'b1}} >> r_lg;
    assign sets     = (aasit_pkg::IDX_W + 1)'(aasit_pkg::NUM_ENTRIES) >> r_lg;
    // tag starts above block offset and the set field (IDX_W - lg bits)
    assign tshift   = aasit_pkg::SHIFT_W'(r_bob)
                    + aasit_pkg::SHIFT_W'(aasit_pkg::IDX_W)
                    - aasit_pkg::SHIFT_W'(r_lg);

    // lookup split
    assign lk_set = aasit_pkg::IDX_W'(i_address >> r_bob) & smask;
    assign lk_tag = i_address >> tshift;

    // place split: set = slot / assoc, way = slot mod assoc
    assign pl_set = i_slot_index >> r_lg;
    assign pl_way = i_slot_index & assoc_m1;

    // associativity request check
    assign na_pow2  = (i_ways_req != '0)
                   && ((i_ways_req & (i_ways_req - aasit_pkg::NA_W'(1))) == '0);
    assign na_ok    = na_pow2 && (i_ways_req <= aasit_pkg::NA_W'(aasit_pkg::MAX_ASSOC));
    assign na_same  = (i_ways_req == (aasit_pkg::NA_W'(1) << r_lg));
    assign assoc_go = na_ok && !na_same;

    always_comb begin
        nl_dec = '0;
        for (int i = 0; i <= aasit_pkg::MAX_LG; i++) begin
            if (i_ways_req[i]) begin
                nl_dec = aasit_pkg::LG_W'(i);
            end
        end
    end

    // rebuild target set: old set mod new set count
    assign ns_mask  = {aasit_pkg::IDX_W{1'b1}} >> r_new_lg;
    assign walk_tgt = (r_cnt >> r_lg) & ns_mask;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            aasit_pkg::S_INIT_CLR: begin
                if (cnt_max) begin
                    n_state = aasit_pkg::S_IDLE;
                end
            end
            aasit_pkg::S_IDLE: begin
                if (accept) begin
                    case (aasit_pkg::t_func'(i_func))
                        aasit_pkg::FUNC_LOOKUP: n_state = aasit_pkg::S_LOOKUP;
                        aasit_pkg::FUNC_ASSOC: begin
                            if (assoc_go) begin
                                n_state = aasit_pkg::S_REB_CLR;
                            end
                        end
                        default: n_state = aasit_pkg::S_IDLE;
                    endcase
                end
            end
            aasit_pkg::S_LOOKUP: begin
                if (r_cnt == assoc_m1) begin
                    n_state = aasit_pkg::S_IDLE;
                end
            end
            aasit_pkg::S_REB_CLR: begin
                if (cnt_max) begin
                    n_state = aasit_pkg::S_REB_RD;
                end
            end
            aasit_pkg::S_REB_RD: begin
                n_state = aasit_pkg::S_REB_FILL;
            end
            aasit_pkg::S_REB_FILL: begin
                if (slot_rdata[aasit_pkg::SLOT_W-1]) begin
                    n_state = aasit_pkg::S_REB_WR;
                end else if (cnt_max) begin
                    n_state = aasit_pkg::S_REB_END;
                end else begin
                    n_state = aasit_pkg::S_REB_RD;
                end
            end
            aasit_pkg::S_REB_WR: begin
                if (cnt_max) begin
                    n_state = aasit_pkg::S_REB_END;
                end else begin
                    n_state = aasit_pkg::S_REB_RD;
                end
            end
            aasit_pkg::S_REB_END: begin
                n_state = aasit_pkg::S_IDLE;
            end
            default: n_state = aasit_pkg::S_IDLE;
        endcase
    end

    // datapath, memory control and results
    always_comb begin
        n_bank    = r_bank;
        n_lg      = r_lg;
        n_new_lg  = r_new_lg;
        n_na      = r_na;
        n_cnt     = r_cnt;
        n_set     = r_set;
        n_tag     = r_tag;
        n_ent     = r_ent;
        n_tgt     = r_tgt;
        n_lk_pend = 1'b0;
        n_lk_way  = r_lk_way;
        n_lk_last = r_lk_last;

        slot_we    = 1'b0;
        slot_waddr = {r_bank, r_cnt};
        slot_wdata = '0;
        slot_raddr = {r_bank, r_cnt};
        fill_we    = 1'b0;
        fill_waddr = r_tgt;
        fill_wdata = '0;
        fill_raddr = walk_tgt;

        n_o_strobe = 1'b0;
        n_o_set    = '0;
        n_o_tag    = '0;
        n_o_way    = '0;
        n_o_ent    = '0;
        n_o_val    = 1'b0;
        n_o_addr   = '0;
        n_o_status = aasit_pkg::STATUS_OK;
        n_o_last   = 1'b0;

        // lookup read data returned this cycle
        if (r_lk_pend) begin
            n_o_strobe = 1'b1;
            n_o_set    = r_set;
            n_o_tag    = r_tag;
            n_o_way    = r_lk_way;
            n_o_ent    = slot_rdata[aasit_pkg::ENTRY_W-1:0];
            n_o_val    = slot_rdata[aasit_pkg::SLOT_W-1];
            n_o_last   = r_lk_last;
        end

        case (r_state)
            aasit_pkg::S_INIT_CLR: begin
                slot_we    = 1'b1;
                slot_waddr = {1'b0, r_cnt};
                n_cnt      = r_cnt + aasit_pkg::IDX_W'(1);
            end
            aasit_pkg::S_IDLE: begin
                if (accept) begin
                    case (aasit_pkg::t_func'(i_func))
                        aasit_pkg::FUNC_LOOKUP: begin
                            n_set = lk_set;
                            n_tag = lk_tag;
                            n_cnt = '0;
                        end
                        aasit_pkg::FUNC_PLACE: begin
                            n_o_strobe = 1'b1;
                            n_o_last   = 1'b1;
                            if ({1'b0, pl_set} < sets) begin
                                slot_we    = 1'b1;
                                slot_waddr = {r_bank, i_slot_index};
                                slot_wdata = {1'b1, i_entry_id};
                                n_o_set    = pl_set;
                                n_o_way    = pl_way;
                                n_o_ent    = i_entry_id;
                                n_o_val    = 1'b1;
                            end else begin
                                n_o_status = aasit_pkg::STATUS_SLOT_RANGE;
                            end
                        end
                        aasit_pkg::FUNC_ASSOC: begin
                            if (assoc_go) begin
                                n_new_lg = nl_dec;
                                n_na     = aasit_pkg::FILL_W'(i_ways_req);
                                n_cnt    = '0;
                            end else begin
                                n_o_strobe = 1'b1;
                                n_o_last   = 1'b1;
                                n_o_status = na_same ? aasit_pkg::STATUS_OK
                                                     : aasit_pkg::STATUS_BAD_ASSOC;
                            end
                        end
                        aasit_pkg::FUNC_REGEN: begin
                            n_o_strobe = 1'b1;
                            n_o_last   = 1'b1;
                            n_o_addr   = (i_tag_in << tshift)
                                       | (aasit_pkg::ADDR_W'(i_set_in) << r_bob);
                        end
                        default: n_o_strobe = 1'b0;
                    endcase
                end
            end
            aasit_pkg::S_LOOKUP: begin
                // one way per cycle, data back next cycle
                slot_raddr = {r_bank, (r_set << r_lg) | r_cnt};
                n_lk_pend  = 1'b1;
                n_lk_way   = r_cnt;
                n_lk_last  = (r_cnt == assoc_m1);
                n_cnt      = r_cnt + aasit_pkg::IDX_W'(1);
            end
            aasit_pkg::S_REB_CLR: begin
                // clear spare bank and fill counters together
                slot_we    = 1'b1;
                slot_waddr = {~r_bank, r_cnt};
                fill_we    = 1'b1;
                fill_waddr = r_cnt;
                n_cnt      = r_cnt + aasit_pkg::IDX_W'(1);
            end
            aasit_pkg::S_REB_RD: begin
                slot_raddr = {r_bank, r_cnt};
            end
            aasit_pkg::S_REB_FILL: begin
                fill_raddr = walk_tgt;
                n_ent      = slot_rdata;
                n_tgt      = walk_tgt;
                if (!slot_rdata[aasit_pkg::SLOT_W-1]) begin
                    n_cnt = r_cnt + aasit_pkg::IDX_W'(1);
                end
            end
            aasit_pkg::S_REB_WR: begin
                // first free way of the target set, dropped if the set is full
                if (fill_rdata < r_na) begin
                    slot_we    = 1'b1;
                    slot_waddr = {~r_bank,
                                  (r_tgt << r_new_lg) | aasit_pkg::IDX_W'(fill_rdata)};
                    slot_wdata = r_ent;
                    fill_we    = 1'b1;
                    fill_waddr = r_tgt;
                    fill_wdata = fill_rdata + aasit_pkg::FILL_W'(1);
                end
                n_cnt = r_cnt + aasit_pkg::IDX_W'(1);
            end
            aasit_pkg::S_REB_END: begin
                n_bank     = ~r_bank;
                n_lg       = r_new_lg;
                n_o_strobe = 1'b1;
                n_o_last   = 1'b1;
            end
            default: n_cnt = r_cnt;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= aasit_pkg::S_INIT_CLR;
            r_bank     <= 1'b0;
            r_lg       <= aasit_pkg::LG_W'(aasit_pkg::INIT_LG);
            r_new_lg   <= '0;
            r_na       <= '0;
            r_bob      <= aasit_pkg::BOB_W'(aasit_pkg::BOB_RESET);
            r_cnt      <= '0;
            r_lk_pend  <= 1'b0;
            r_o_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_bank     <= n_bank;
            r_lg       <= n_lg;
            r_new_lg   <= n_new_lg;
            r_na       <= n_na;
            r_cnt      <= n_cnt;
            r_lk_pend  <= n_lk_pend;
            r_o_strobe <= n_o_strobe;
            if (i_cfg_we) begin
                r_bob <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_set      <= n_set;
        r_tag      <= n_tag;
        r_ent      <= n_ent;
        r_tgt      <= n_tgt;
        r_lk_way   <= n_lk_way;
        r_lk_last  <= n_lk_last;
        r_o_set    <= n_o_set;
        r_o_tag    <= n_o_tag;
        r_o_way    <= n_o_way;
        r_o_ent    <= n_o_ent;
        r_o_val    <= n_o_val;
        r_o_addr   <= n_o_addr;
        r_o_status <= n_o_status;
        r_o_last   <= n_o_last;
    end

    assign o_strobe      = r_o_strobe;
    assign o_set_index   = r_o_set;
    assign o_tag_out     = r_o_tag;
    assign o_way         = r_o_way;
    assign o_entry_out   = r_o_ent;
    assign o_entry_valid = r_o_val;
    assign o_address_out = r_o_addr;
    assign o_status      = r_o_status;
    assign o_last        = r_o_last;

endmodule

`default_nettype wire
